// File: hdl/swsd_pkg.sv
package swsd_pkg;

	// default sizes handed down from the top level
	localparam int WINDOW_MAX_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int FILL_W     = 11;
	localparam int LEN_W      = 11;
	localparam int K_W        = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_K_QUARTERS = 2'd2;

	// register reset values
	localparam logic [LEN_W-1:0] WINDOW_LEN_RST = 11'd1000;
	localparam logic [LEN_W-1:0] MIN_COUNT_RST  = 11'd100;
	localparam logic [K_W-1:0]   K_QUARTERS_RST = 6'd6;

	// shared multiplier slices its operands into chunks of this width
	localparam int MUL_CHUNK = 32;

	// products formed on the shared multiplier
	localparam int MUL_SEL_W = 2;
	localparam logic [MUL_SEL_W-1:0] MUL_DSQ = 2'd0;
	localparam logic [MUL_SEL_W-1:0] MUL_SSQ = 2'd1;
	localparam logic [MUL_SEL_W-1:0] MUL_NQ  = 2'd2;
	localparam logic [MUL_SEL_W-1:0] MUL_RHS = 2'd3;

	typedef struct packed {
		logic                 load_x;
		logic                 rd_oldest;
		logic                 drop;
		logic                 write_new;
		logic                 calc_nx;
		logic                 calc_d;
		logic                 mul_start;
		logic [MUL_SEL_W-1:0] mul_sel;
		logic                 calc_var;
		logic                 calc_spike;
		logic                 load_res;
	} swsd_cmd_t;

	typedef struct packed {
		logic need_drop;
		logic pass;
		logic mul_done;
		logic res_full;
	} swsd_sts_t;

endpackage

// File: hdl/swsd_ram.sv
module swsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/swsd_mul.sv
module swsd_mul #(
	parameter int A_W = 64,
	parameter int B_W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);
	import swsd_pkg::*;

	localparam int CH    = MUL_CHUNK;
	localparam int NA    = (A_W + CH - 1) / CH;
	localparam int NB    = (B_W + CH - 1) / CH;
	localparam int IA_W  = (NA > 1) ? $clog2(NA) : 1;
	localparam int IB_W  = (NB > 1) ? $clog2(NB) : 1;
	localparam int SH_W  = $clog2(NA + NB);
	localparam int ACC_W = (NA + NB) * CH;

	logic [NA*CH-1:0] a_q;
	logic [NB*CH-1:0] b_q;
	logic [IA_W-1:0]  ia_q;
	logic [IB_W-1:0]  ib_q;
	logic             run_q;
	logic [2*CH-1:0]  p_s1;
	logic [SH_W-1:0]  sh_s1;
	logic             v_s1;
	logic             last_s1;
	logic [ACC_W-1:0] acc_q;
	logic             done_q;

	logic             last_pair;
	logic [CH-1:0]    a_chunk;
	logic [CH-1:0]    b_chunk;

	assign last_pair = (ia_q == IA_W'(NA - 1)) && (ib_q == IB_W'(NB - 1));
	assign a_chunk   = a_q[ia_q*CH +: CH];
	assign b_chunk   = b_q[ib_q*CH +: CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			ia_q    <= '0;
			ib_q    <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				ia_q  <= '0;
				ib_q  <= '0;
			end else if (run_q) begin
				if (ia_q == IA_W'(NA - 1)) begin
					ia_q <= '0;
					ib_q <= ib_q + 1'b1;
				end else begin
					ia_q <= ia_q + 1'b1;
				end
				if (last_pair) begin
					run_q <= 1'b0;
				end
			end
			v_s1    <= run_q;
			last_s1 <= run_q && last_pair;
			done_q  <= v_s1 && last_s1;
		end
	end

	// one chunk pair per cycle; its registered product is accumulated in the next cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= (NA*CH)'(a);
			b_q   <= (NB*CH)'(b);
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= acc_q + (ACC_W'(p_s1) << (CH * sh_s1));
		end
		if (run_q) begin
			p_s1  <= (2*CH)'(a_chunk) * (2*CH)'(b_chunk);
			sh_s1 <= SH_W'(ia_q) + SH_W'(ib_q);
		end
	end

	assign done = done_q;
	assign prod = acc_q[A_W+B_W-1:0];

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!run_q && !v_s1))
		else $error("multiply started while one is in flight");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("multiply done held for more than one cycle");
`endif

endmodule

// File: hdl/swsd_datapath.sv
module swsd_datapath #(
	parameter int WINDOW_MAX  = swsd_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [swsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swsd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [swsd_pkg::SAMPLE_W-1:0]   sample,
	input  swsd_pkg::swsd_cmd_t             cmd,
	output swsd_pkg::swsd_sts_t             sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            spike,
	output logic                            armed,
	output logic [swsd_pkg::FILL_W-1:0]     fill_count
);
	import swsd_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int PTR_W  = $clog2(WINDOW_MAX);
	localparam int IDX_W  = CNT_W + 1;
	localparam int CL_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int S_W    = SB + CNT_W;
	localparam int SQ_W   = 2 * SB + CNT_W;
	localparam int D_W    = S_W;
	localparam int VAR_W  = 2 * S_W;
	localparam int NQ_W   = CNT_W + SQ_W;
	localparam int K2_W   = 2 * K_W;
	localparam int RHS_W  = VAR_W + K2_W;
	localparam int DSQ_W  = 2 * D_W;
	localparam int A_W    = VAR_W;
	localparam int B_W    = (D_W > K2_W) ? D_W : K2_W;
	localparam int P_W    = A_W + B_W;
	localparam int CMP_W  = (DSQ_W + 4 > RHS_W) ? DSQ_W + 4 : RHS_W;

	// configuration
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] minc_q;
	logic [K_W-1:0]   k_q;

	// window state
	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] count_q;
	logic [S_W-1:0]   s_q;
	logic [SQ_W-1:0]  q_q;

	// per item working registers
	logic [SB-1:0]        x_q;
	logic [S_W-1:0]       nx_q;
	logic                 armed_q;
	logic [DSQ_W-1:0]     dsq_q;
	logic [VAR_W-1:0]     ssq_q;
	logic [NQ_W-1:0]      nq_q;
	logic [VAR_W-1:0]     var_q;
	logic [RHS_W-1:0]     rhs_q;
	logic                 spike_q;
	logic [MUL_SEL_W-1:0] mul_sel_q;

	// result register
	logic              out_valid_q;
	logic              res_spike_q;
	logic              res_armed_q;
	logic [FILL_W-1:0] res_fill_q;

	logic [SB+SAMPLE_W-1:0] x_ext;
	logic [SB-1:0]          x_in;
	logic [CL_W-1:0]        len_ext;
	logic [CL_W-1:0]        eff_len;
	logic [IDX_W-1:0]       wp_x;
	logic [IDX_W-1:0]       cnt_x;
	logic [IDX_W-1:0]       old_x;
	logic [PTR_W-1:0]       wp_next;
	logic [SB-1:0]          rd_data;
	logic [SB-1:0]          sq_op;
	logic [2*SB-1:0]        sq;
	logic [K2_W-1:0]        k2;
	logic [D_W-1:0]         d_now;
	logic [A_W-1:0]         mul_a;
	logic [B_W-1:0]         mul_b;
	logic                   mul_done;
	logic [P_W-1:0]         mul_prod;
	logic                   res_full;

	assign x_ext = {{SB{1'b0}}, sample};
	assign x_in  = x_ext[SB-1:0];

	// zero length behaves as one, long lengths saturate at the ring size
	assign len_ext = CL_W'(len_q);
	always_comb begin
		if (len_q == '0) begin
			eff_len = CL_W'(1);
		end else if (len_ext > CL_W'(WINDOW_MAX)) begin
			eff_len = CL_W'(WINDOW_MAX);
		end else begin
			eff_len = len_ext;
		end
	end

	// oldest entry sits count places behind the write pointer
	assign wp_x  = IDX_W'(wp_q);
	assign cnt_x = IDX_W'(count_q);
	assign old_x = (wp_x >= cnt_x) ? (wp_x - cnt_x) : (wp_x + IDX_W'(WINDOW_MAX) - cnt_x);

	assign wp_next = (wp_q == PTR_W'(WINDOW_MAX - 1)) ? '0 : (wp_q + 1'b1);

	// one squarer serves both the drop and the add
	assign sq_op = cmd.drop ? rd_data : x_q;
	assign sq    = (2*SB)'(sq_op) * (2*SB)'(sq_op);

	assign k2 = K2_W'(k_q) * K2_W'(k_q);

	// deviation goes straight to the multiplier in the cycle the test passes
	assign d_now = nx_q - s_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_DSQ: begin
				mul_a = A_W'(d_now);
				mul_b = B_W'(d_now);
			end
			MUL_SSQ: begin
				mul_a = A_W'(s_q);
				mul_b = B_W'(s_q);
			end
			MUL_NQ: begin
				mul_a = A_W'(q_q);
				mul_b = B_W'(count_q);
			end
			MUL_RHS: begin
				mul_a = A_W'(var_q);
				mul_b = B_W'(k2);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	swsd_ram #(
		.WIDTH (SB),
		.DEPTH (WINDOW_MAX)
	) u_ram (
		.clk   (clk),
		.we    (cmd.write_new),
		.waddr (wp_q),
		.wdata (x_q),
		.re    (cmd.rd_oldest),
		.raddr (old_x[PTR_W-1:0]),
		.rdata (rd_data)
	);

	swsd_mul #(
		.A_W (A_W),
		.B_W (B_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign res_full = out_valid_q && !out_ready;

	assign sts.need_drop = CL_W'(count_q) >= eff_len;
	assign sts.pass      = armed_q && (nx_q > s_q);
	assign sts.mul_done  = mul_done;
	assign sts.res_full  = res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= WINDOW_LEN_RST;
			minc_q      <= MIN_COUNT_RST;
			k_q         <= K_QUARTERS_RST;
			wp_q        <= '0;
			count_q     <= '0;
			s_q         <= '0;
			q_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_WINDOW_LEN: len_q  <= cfg_data[LEN_W-1:0];
					REG_MIN_COUNT:  minc_q <= cfg_data[LEN_W-1:0];
					REG_K_QUARTERS: k_q    <= cfg_data[K_W-1:0];
					default: ;
				endcase
			end
			if (cmd.drop) begin
				count_q <= count_q - 1'b1;
				s_q     <= s_q - S_W'(rd_data);
				q_q     <= q_q - SQ_W'(sq);
			end else if (cmd.write_new) begin
				wp_q    <= wp_next;
				count_q <= count_q + 1'b1;
				s_q     <= s_q + S_W'(x_q);
				q_q     <= q_q + SQ_W'(sq);
			end
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= x_in;
		end
		if (cmd.calc_nx) begin
			nx_q    <= S_W'(count_q) * S_W'(x_q);
			armed_q <= CL_W'(count_q) > CL_W'(minc_q);
		end
		if (cmd.calc_d) begin
			spike_q <= 1'b0;
		end else if (cmd.calc_spike) begin
			// 16 * d^2 against k^2 * (N*Q - S^2)
			spike_q <= CMP_W'({dsq_q, 4'b0000}) > CMP_W'(rhs_q);
		end
		if (cmd.mul_start) begin
			mul_sel_q <= cmd.mul_sel;
		end
		if (mul_done) begin
			case (mul_sel_q)
				MUL_DSQ: dsq_q <= mul_prod[DSQ_W-1:0];
				MUL_SSQ: ssq_q <= mul_prod[VAR_W-1:0];
				MUL_NQ:  nq_q  <= mul_prod[NQ_W-1:0];
				MUL_RHS: rhs_q <= mul_prod[RHS_W-1:0];
				default: ;
			endcase
		end
		if (cmd.calc_var) begin
			var_q <= VAR_W'(nq_q) - ssq_q;
		end
		if (cmd.load_res) begin
			res_spike_q <= spike_q;
			res_armed_q <= armed_q;
			res_fill_q  <= FILL_W'(count_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign spike      = res_spike_q;
	assign armed      = res_armed_q;
	assign fill_count = res_fill_q;

`ifndef SYNTHESIS
	a_drop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |-> $past(cmd.rd_oldest))
		else $error("sample dropped without a ring read the cycle before");
	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc_nx |-> (count_q != '0 && CL_W'(count_q) <= eff_len))
		else $error("window count outside one to window length after the add");
	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> !res_full)
		else $error("result loaded over one still waiting for transfer");
`endif

endmodule

// File: hdl/swsd_ctrl.sv
module swsd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  swsd_pkg::swsd_sts_t sts,
	output swsd_pkg::swsd_cmd_t cmd
);
	import swsd_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_DROP  = 4'd2;
	localparam logic [3:0] ST_WRITE = 4'd3;
	localparam logic [3:0] ST_NX    = 4'd4;
	localparam logic [3:0] ST_TEST  = 4'd5;
	localparam logic [3:0] ST_W_DSQ = 4'd6;
	localparam logic [3:0] ST_W_SSQ = 4'd7;
	localparam logic [3:0] ST_W_NQ  = 4'd8;
	localparam logic [3:0] ST_VAR   = 4'd9;
	localparam logic [3:0] ST_M_RHS = 4'd10;
	localparam logic [3:0] ST_W_RHS = 4'd11;
	localparam logic [3:0] ST_CMP   = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_x = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// drop oldest samples until there is room for the new one
				if (sts.need_drop) begin
					cmd.rd_oldest = 1'b1;
					state_d       = ST_DROP;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_DROP: begin
				cmd.drop = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_WRITE: begin
				cmd.write_new = 1'b1;
				state_d       = ST_NX;
			end
			ST_NX: begin
				cmd.calc_nx = 1'b1;
				state_d     = ST_TEST;
			end
			ST_TEST: begin
				cmd.calc_d = 1'b1;
				if (sts.pass) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_DSQ;
					state_d       = ST_W_DSQ;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_W_DSQ: begin
				if (sts.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_SSQ;
					state_d       = ST_W_SSQ;
				end
			end
			ST_W_SSQ: begin
				if (sts.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_NQ;
					state_d       = ST_W_NQ;
				end
			end
			ST_W_NQ: begin
				if (sts.mul_done) begin
					state_d = ST_VAR;
				end
			end
			ST_VAR: begin
				cmd.calc_var = 1'b1;
				state_d      = ST_M_RHS;
			end
			ST_M_RHS: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_RHS;
				state_d       = ST_W_RHS;
			end
			ST_W_RHS: begin
				if (sts.mul_done) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.calc_spike = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.res_full) begin
					cmd.load_res = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/sliding_window_spike_detector.sv
// Sliding window spike detector: each transfer on the input channel brings one luminance
// sample; the block keeps the last window_len samples (1 to WINDOW_MAX) in a ring memory
// with their running sum S and sum of squares Q, and returns one result per sample: fill
// count, armed (count above min_count) and spike, the exact integer test
// N*x - S > 0 and 16(N*x - S)^2 > k_quarters^2 (N*Q - S^2). Samples are handled one at a
// time. Each old sample dropped takes one ring read and one update; normally one is
// dropped per sample once the window is full, more after window_len is lowered. When
// the window is armed and the sample lies above the mean, the test uses the single
// shared multiplier, which forms the four wide products one 32x32 partial product per
// cycle, with 2 partial products per multiply at default sizes. The next sample is
// taken while a result still waits for transfer. The ring needs no clearing after
// reset, and configuration registers are to be written by the user only while idle;
// the block itself does not enforce this.
module sliding_window_spike_detector #(
	parameter int WINDOW_MAX  = swsd_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [swsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swsd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [swsd_pkg::SAMPLE_W-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            spike,
	output logic                            armed,
	output logic [swsd_pkg::FILL_W-1:0]     fill_count
);
	import swsd_pkg::*;

	swsd_cmd_t cmd;
	swsd_sts_t sts;

	swsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swsd_datapath #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.spike      (spike),
		.armed      (armed),
		.fill_count (fill_count)
	);

endmodule
